@@ hdl/mlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// mlpd_pkg
// Shared constants and types for the multi-level long-press detector.
// ----------------------------------------------------------------------------
package mlpd_pkg;

    // Default number of press thresholds (legal range 1..5)
    localparam int MLPD_MAX_LEVELS = 5;

    // Field widths
    localparam int LVL_W      = 3;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 40;

    // Saturation value of the elapsed counter
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // Request kinds carried on s_tuser
    typedef enum logic
    {
        OP_TICK  = 1'b0,
        OP_CLEAR = 1'b1
    } opcode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVEL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_LEVELS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD_1  = 3'd2;

    // One result request
    typedef struct packed
    {
        logic             level_up;
        logic             max_reached;
        logic             is_pressed;
        logic [CNT_W-1:0] held_ms;
        logic [LVL_W-1:0] press_level;
        logic             bounce_dropped;
        logic             long_release;
    } result_t;

endpackage

@@ hdl/multi_level_long_press_detector_core.sv @@
// ----------------------------------------------------------------------------
// multi_level_long_press_detector_core
// Times button presses on millisecond ticks and grades them into levels.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one request per millisecond tick. s_tuser selects
//   a tick carrying the pin sample in s_tdata[0], or a clear command that
//   zeroes the press level, elapsed count and max flag.
//   Master channel (m_*): exactly one result per request, in order.
//   Config channel (cfg_*): register writes, always ready; write only
//   while the block is idle. Index 0 active level, 1 level count,
//   2..6 thresholds 1..5 in ms.
// Result: a result shows on m_* in the cycle after its request is taken.
// Throughput: one request per cycle while m_tready is high. The whole update (counter step,
//   parallel threshold compares, level select) sits between the accepting
//   edge and the single result register.
// Reset: pin history is the inactive level (1), no press is timed, level,
//   count and max flag are zero; registers take their reset values.
// Stall: while m_tready is low and a result is held, the result register holds
//   and s_tready drops, so no request is taken until the result is drained.
// ----------------------------------------------------------------------------
module multi_level_long_press_detector_core
    import mlpd_pkg::*;
#(
    parameter int MAX_LEVELS = MLPD_MAX_LEVELS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // request stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,   // [0] pin_level, [7:1] zero
    input  logic                  s_tuser,   // [0] opcode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,   // [0] long_release,
                                             // [1] bounce_dropped,
                                             // [4:2] press_level,
                                             // [36:5] held_ms,
                                             // [37] is_pressed,
                                             // [38] max_reached,
                                             // [39] level_up
    // configuration writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [LVL_W-1:0] MAX_LVL = LVL_W'(MAX_LEVELS);

    // Configuration registers
    logic                        active_level_reg;
    logic [LVL_W-1:0]            num_levels_reg;
    logic [MAX_LEVELS-1:0][CNT_W-1:0] thr_reg;

    // Press state
    logic                        last_pin_reg;
    logic                        timing_reg;
    logic [CNT_W-1:0]            elapsed_reg;
    logic [LVL_W-1:0]            level_reg;
    logic                        max_reg;

    logic                        last_pin_next;
    logic                        timing_next;
    logic [CNT_W-1:0]            elapsed_next;
    logic [LVL_W-1:0]            level_next;
    logic                        max_next;

    // Result register
    logic                        m_valid_reg;
    result_t                     result_reg;
    result_t                     result_next;

    logic                        accept;
    logic                        pin;
    logic                        pin_active;
    logic                        started;
    logic                        released;
    logic                        run;
    logic [CNT_W-1:0]            cnt_inc;
    logic [CNT_W-1:0]            cnt_run;
    logic [LVL_W-1:0]            n_use;
    logic [LVL_W-1:0]            lvl_hit;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = result_reg;

    assign pin        = s_tdata[0];
    assign pin_active = (pin == active_level_reg);

    // Levels in use, clamped to 1..MAX_LEVELS
    always_comb
    begin
        if (num_levels_reg == '0)
            n_use = LVL_W'(1);
        else if (num_levels_reg > MAX_LVL)
            n_use = MAX_LVL;
        else
            n_use = num_levels_reg;
    end

    // Press edge detection and counter step
    assign started  = (pin != last_pin_reg) && pin_active;
    assign released = (pin != last_pin_reg) && !pin_active && timing_reg;
    assign cnt_inc  = (elapsed_reg == CNT_MAX) ? elapsed_reg : elapsed_reg + CNT_W'(1);
    assign cnt_run  = started ? '0 : cnt_inc;
    assign run      = !released && (timing_reg || started) && pin_active;

    // Highest threshold reached, compares in parallel
    always_comb
    begin
        lvl_hit = '0;
        for (int i = 0; i < MAX_LEVELS; i++)
        begin
            if ((LVL_W'(i) < n_use) && (cnt_run >= thr_reg[i]))
                lvl_hit = LVL_W'(i + 1);
        end
    end

    // Next state and result
    always_comb
    begin
        last_pin_next = last_pin_reg;
        timing_next   = timing_reg;
        elapsed_next  = elapsed_reg;
        level_next    = level_reg;
        max_next      = max_reg;
        result_next   = '0;

        if (opcode_t'(s_tuser) == OP_CLEAR)
        begin
            level_next   = '0;
            elapsed_next = '0;
            max_next     = 1'b0;
        end
        else
        begin
            last_pin_next = pin;
            if (started)
                timing_next = 1'b1;
            else if (released)
            begin
                timing_next  = 1'b0;
                elapsed_next = cnt_inc;
                if (cnt_inc > thr_reg[0])
                    result_next.long_release = 1'b1;
                else
                begin
                    result_next.bounce_dropped = 1'b1;
                    level_next   = '0;
                    elapsed_next = '0;
                    max_next     = 1'b0;
                end
            end

            if (run)
            begin
                elapsed_next = cnt_run;
                if (lvl_hit > level_reg)
                begin
                    level_next           = lvl_hit;
                    result_next.level_up = 1'b1;
                end
                if (level_next == n_use)
                    max_next = 1'b1;
            end
        end

        result_next.press_level = level_next;
        result_next.held_ms     = elapsed_next;
        result_next.is_pressed  = timing_next && (last_pin_next == active_level_reg);
        result_next.max_reached = max_next;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_level_reg <= 1'b0;
            num_levels_reg   <= LVL_W'(1);
            thr_reg          <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ACTIVE_LEVEL)
                active_level_reg <= cfg_data[0];
            if (cfg_index == CFG_NUM_LEVELS)
                num_levels_reg <= cfg_data[LVL_W-1:0];
            for (int i = 0; i < MAX_LEVELS; i++)
            begin
                if (cfg_index == CFG_THRESHOLD_1 + CFG_IDX_W'(i))
                    thr_reg[i] <= cfg_data[CNT_W-1:0];
            end
        end
    end

    // Press state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_pin_reg <= 1'b1;
            timing_reg   <= 1'b0;
            elapsed_reg  <= '0;
            level_reg    <= '0;
            max_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                last_pin_reg <= last_pin_next;
                timing_reg   <= timing_next;
                elapsed_reg  <= elapsed_next;
                level_reg    <= level_next;
                max_reg      <= max_next;
                m_valid_reg  <= 1'b1;
            end
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-level long-press detector core. Queued
// tick and clear requests are sent with random gaps. Each accepted request
// runs through a local model of the press timer, and each result request
// is checked against the oldest prediction. Several register settings are
// applied between drained phases, including out-of-range level counts and
// extreme thresholds.
// ----------------------------------------------------------------------------
module tb
    import mlpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed
    {
        opcode_t op;
        logic    pin;
    } tick_req_t;

    localparam int RANDOM_TICKS = 1850;

    // DUT ports, all known from time zero
    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata   = '0;
    logic                  s_tuser   = OP_TICK;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    // Local copy of the register file
    logic             act_lvl = 1'b0;
    logic [LVL_W-1:0] lvl_cnt = 3'd1;
    logic [CNT_W-1:0] thresh [5] = '{default: '0};

    // Local copy of the press timer state
    logic             pin_hist = 1'b1;
    logic             timing   = 1'b0;
    logic [CNT_W-1:0] held     = '0;
    logic [LVL_W-1:0] lvl      = '0;
    logic             maxf     = 1'b0;

    // Request queues and bookkeeping
    tick_req_t tick_queue [$];
    result_t   expected_reports [$];
    tick_req_t offered;
    int        ticks_issued    = 0;
    int        reports_checked = 0;
    int        mismatches      = 0;
    int        send_gap        = 0;
    int        recv_stall      = 0;
    int        next_hold_at    = 150;
    bit        calm            = 1'b0;

    multi_level_long_press_detector_core u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Run limit, far above the slowest legal run
    initial
    begin
        #2_000_000;
        $display("tb: done, errors");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Press timer model
    // ------------------------------------------------------------------------
    function automatic void drop_press();
        lvl  = '0;
        held = '0;
        maxf = 1'b0;
    endfunction

    function automatic result_t detector_step(tick_req_t req);
        result_t res;
        logic    started;
        logic    released;
        int      n;
        int      hit;
        res      = '0;
        started  = 1'b0;
        released = 1'b0;
        if (req.op == OP_CLEAR)
            drop_press();
        else
        begin
            // pin edge: start a press, or end one
            if (req.pin != pin_hist)
            begin
                pin_hist = req.pin;
                if (req.pin == act_lvl)
                begin
                    timing  = 1'b1;
                    held    = '0;
                    started = 1'b1;
                end
                else if (timing)
                begin
                    timing   = 1'b0;
                    released = 1'b1;
                    if (held != CNT_MAX)
                        held++;
                    if (held > thresh[0])
                        res.long_release = 1'b1;
                    else
                    begin
                        drop_press();
                        res.bounce_dropped = 1'b1;
                    end
                end
            end
            // still held: count and grade
            if (!released && timing && pin_hist == act_lvl)
            begin
                if (!started && held != CNT_MAX)
                    held++;
                n = (lvl_cnt > MLPD_MAX_LEVELS) ? MLPD_MAX_LEVELS : int'(lvl_cnt);
                if (n == 0)
                    n = 1;
                hit = 0;
                for (int i = 0; i < n; i++)
                    if (held >= thresh[i])
                        hit = i + 1;
                if (hit > lvl)
                begin
                    lvl = LVL_W'(hit);
                    res.level_up = 1'b1;
                end
                if (lvl == n)
                    maxf = 1'b1;
            end
        end
        res.press_level = lvl;
        res.held_ms     = held;
        res.is_pressed  = timing && (pin_hist == act_lvl);
        res.max_reached = maxf;
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Request driver
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic      next_valid;
        tick_req_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            next_valid = s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_reports.push_back(detector_step(offered));
                next_valid = 1'b0;
                send_gap   = calm ? 0 : $urandom_range(0, 4);
            end
            if (!next_valid)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (tick_queue.size() > 0)
                begin
                    req     = tick_queue.pop_front();
                    offered = req;
                    s_tdata <= {{(S_DATA_W-1){1'b0}}, req.pin};
                    s_tuser <= req.op;
                    next_valid = 1'b1;
                end
            end
            s_tvalid <= next_valid;
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor
    // ------------------------------------------------------------------------
    function automatic void compare_field(string name, logic [CNT_W-1:0] want,
                                          logic [CNT_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin
        result_t seen;
        result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen = result_t'(m_tdata);
                if (expected_reports.size() == 0)
                begin
                    $error("result request with no prediction outstanding");
                    mismatches++;
                end
                else
                begin
                    want = expected_reports.pop_front();
                    compare_field("long_release", CNT_W'(want.long_release),
                                  CNT_W'(seen.long_release));
                    compare_field("bounce_dropped", CNT_W'(want.bounce_dropped),
                                  CNT_W'(seen.bounce_dropped));
                    compare_field("press_level", CNT_W'(want.press_level),
                                  CNT_W'(seen.press_level));
                    compare_field("held_ms", want.held_ms, seen.held_ms);
                    compare_field("is_pressed", CNT_W'(want.is_pressed),
                                  CNT_W'(seen.is_pressed));
                    compare_field("max_reached", CNT_W'(want.max_reached),
                                  CNT_W'(seen.max_reached));
                    compare_field("level_up", CNT_W'(want.level_up),
                                  CNT_W'(seen.level_up));
                end
                reports_checked++;
                recv_stall = calm ? 0 : $urandom_range(0, 4);
                // long hold-off while requests keep coming, to back up the input
                if (reports_checked >= next_hold_at && tick_queue.size() > 20)
                begin
                    recv_stall = 64;
                    next_hold_at += 700;
                end
            end
            if (recv_stall > 0)
            begin
                recv_stall--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    task automatic queue_tick(opcode_t op, logic pin);
        tick_req_t req;
        req.op  = op;
        req.pin = pin;
        tick_queue.push_back(req);
        ticks_issued++;
    endtask

    // Called on a rising edge; returns on the edge that takes the write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_ACTIVE_LEVEL: act_lvl = val[0];
            CFG_NUM_LEVELS:   lvl_cnt = val[LVL_W-1:0];
            default:          thresh[idx - CFG_THRESHOLD_1] = val;
        endcase
    endtask

    // Thresholds are packed from threshold 5 down to threshold 1
    task automatic apply_config(logic act, logic [LVL_W-1:0] n,
                                logic [4:0][CNT_W-1:0] thr);
        int i;
        write_reg(CFG_ACTIVE_LEVEL, {{(CFG_DATA_W-1){1'b0}}, act});
        write_reg(CFG_NUM_LEVELS, {{(CFG_DATA_W-LVL_W){1'b0}}, n});
        for (i = 0; i < 5; i++)
            write_reg(CFG_THRESHOLD_1 + CFG_IDX_W'(i), thr[i]);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (reports_checked < ticks_issued)
            @(posedge clk);
    endtask

    function automatic logic [4:0][CNT_W-1:0] draw_thresholds();
        logic [4:0][CNT_W-1:0] thr;
        int                    acc;
        int                    sel;
        int                    i;
        sel = $urandom_range(0, 7);
        acc = $urandom_range(0, 6);
        for (i = 0; i < 5; i++)
        begin
            thr[i] = acc;
            acc += $urandom_range(0, 8);
        end
        if (sel == 0)
            thr = '0;
        else if (sel == 1)
            for (i = 0; i < 5; i++)
                thr[i] = $urandom_range(0, 30);
        else if (sel == 2)
            thr[3'($urandom_range(0, 4))] = CNT_MAX;
        return thr;
    endfunction

    // Idle lead-in, press, optional mid-press clear, release, optional clear
    task automatic queue_press();
        int   lead;
        int   hold;
        int   span;
        int   cut;
        int   i;
        logic idle_pin;
        idle_pin = ~act_lvl;
        lead     = $urandom_range(0, 3);
        span     = 8;
        for (i = 0; i < 5; i++)
            if (thresh[i] < 45 && thresh[i] + 4 > span)
                span = thresh[i] + 4;
        // aim at the bounce / long-release boundary about a third of the time
        if (thresh[0] < 40 && $urandom_range(0, 2) == 0)
            hold = ((thresh[0] == 0) ? 0 : int'(thresh[0]) - 1) + $urandom_range(0, 1);
        else
            hold = $urandom_range(0, span);
        cut = ($urandom_range(0, 9) == 0) ? $urandom_range(0, hold) : -1;
        repeat (lead)
            queue_tick(OP_TICK, idle_pin);
        queue_tick(OP_TICK, act_lvl);
        for (i = 0; i < hold; i++)
        begin
            if (i == cut)
                queue_tick(OP_CLEAR, 1'($urandom_range(0, 1)));
            queue_tick(OP_TICK, act_lvl);
        end
        queue_tick(OP_TICK, idle_pin);
        if ($urandom_range(0, 1))
            queue_tick(OP_CLEAR, 1'($urandom_range(0, 1)));
    endtask

    task automatic queue_noise();
        int count;
        count = $urandom_range(1, 8);
        repeat (count)
            queue_tick(($urandom_range(0, 5) == 0) ? OP_CLEAR : OP_TICK,
                       1'($urandom_range(0, 1)));
    endtask

    initial
    begin
        int directed_ticks;
        int phase_end;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Active low, three levels: idle tick, climb to max, long release,
        // clear, bounce, clear while held
        apply_config(1'b0, 3'd3, {32'd0, CNT_MAX, 32'd3, 32'd2, 32'd1});
        queue_tick(OP_TICK, 1'b1);
        queue_tick(OP_TICK, 1'b0);
        repeat (3)
            queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        queue_tick(OP_CLEAR, 1'b1);
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_CLEAR, 1'b0);
        repeat (2)
            queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        wait_drained();

        // Active high, level count above the maximum, first two thresholds zero:
        // release without timing, levels graded on the start tick
        apply_config(1'b1, 3'd7, {32'd2, 32'd1, 32'd1, 32'd0, 32'd0});
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        repeat (2)
            queue_tick(OP_TICK, 1'b1);
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_CLEAR, 1'b0);
        wait_drained();

        // Level count zero, unreachable first threshold: every press bounces
        apply_config(1'b0, 3'd0, {CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX, CNT_MAX});
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        queue_tick(OP_TICK, 1'b0);
        queue_tick(OP_TICK, 1'b1);
        wait_drained();
        directed_ticks = ticks_issued;

        // Random phases, each under a fresh register setting
        while (ticks_issued < directed_ticks + RANDOM_TICKS)
        begin
            calm = ($urandom_range(0, 3) == 0);
            apply_config(1'($urandom_range(0, 1)),
                         ($urandom_range(0, 7) == 0) ? LVL_W'($urandom_range(0, 7))
                                                     : LVL_W'($urandom_range(1, 5)),
                         draw_thresholds());
            phase_end = ticks_issued + $urandom_range(60, 140);
            while (ticks_issued < phase_end)
            begin
                if ($urandom_range(0, 9) < 2)
                    queue_noise();
                else
                    queue_press();
            end
            wait_drained();
        end

        repeat (8)
            @(posedge clk);
        if (mismatches == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

@@ files.f @@
hdl/mlpd_pkg.sv
hdl/multi_level_long_press_detector_core.sv
bench/tb.sv
